// ===== src/hcd_pkg.sv =====
// shared types and constants for the hill cipher decrypt block
package hcd_pkg;

    localparam int DATA_W    = 21;
    localparam int ORD_W     = 2;
    localparam int KEY_W     = 8;
    localparam int ROW_W     = 3 * KEY_W;
    localparam int ADJ_W     = 18;
    localparam int DET_W     = 28;
    localparam int PROD_W    = DATA_W + ADJ_W;
    localparam int NUM_W     = 40;
    localparam int DVD_W     = 40;
    localparam int DVS_W     = 28;
    localparam int BYTE_W    = 8;
    localparam int VEC_SLOTS = 3;

    typedef logic signed [DATA_W-1:0] cval_t;

    typedef struct packed {
        cval_t [VEC_SLOTS-1:0] vec;
        logic [ORD_W-1:0]      order;
        logic                  fin;
    } block_t;

    typedef struct packed {
        logic [ORD_W-1:0]          order;
        logic [2:0][ROW_W-1:0]     key_rows;
    } cfg_t;

    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] quo;
    } div_out_t;

endpackage

// ===== src/hcd_front.sv =====
// front end: gathers ciphertext values into blocks and queues closed blocks
module hcd_front
    import hcd_pkg::*;
#(
    parameter int MAX_ORDER = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  cval_t            s_cipher_value,
    input  logic             s_final_value,
    input  logic [ORD_W-1:0] cfg_order,
    input  logic             queue_full,
    output logic             push,
    output block_t           push_data
);

    logic [ORD_W-1:0] fill_reg;
    logic [ORD_W-1:0] fill_next;
    cval_t            vec_reg [MAX_ORDER];
    logic [ORD_W-1:0] eff_order;
    logic [ORD_W:0]   fill_inc;
    logic             accept;
    logic             close;

    always_comb begin
        if (cfg_order == '0) begin
            eff_order = ORD_W'(1);
        end else if (cfg_order > ORD_W'(MAX_ORDER)) begin
            eff_order = ORD_W'(MAX_ORDER);
        end else begin
            eff_order = cfg_order;
        end
    end

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign fill_inc = {1'b0, fill_reg} + (ORD_W+1)'(1);
    assign close    = (fill_inc >= {1'b0, eff_order}) || s_final_value;
    assign push     = accept && close;
    assign fill_next = close ? '0 : fill_inc[ORD_W-1:0];

    assign push_data.order = eff_order;
    assign push_data.fin   = s_final_value;

    for (genvar k = 0; k < VEC_SLOTS; k++) begin : g_slot
        if (k < MAX_ORDER) begin : g_used
            always_comb begin
                if (fill_reg == ORD_W'(k)) begin
                    push_data.vec[k] = s_cipher_value;
                end else if (fill_reg > ORD_W'(k)) begin
                    push_data.vec[k] = vec_reg[k];
                end else begin
                    push_data.vec[k] = '0;
                end
            end
            always_ff @(posedge aclk) begin
                if (accept && fill_reg == ORD_W'(k)) begin
                    vec_reg[k] <= s_cipher_value;
                end
            end
        end else begin : g_unused
            assign push_data.vec[k] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== src/hcd_queue.sv =====
// two-entry block queue between front and back
module hcd_queue
    import hcd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  block_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output block_t q_data
);

    block_t     mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== src/hcd_div.sv =====
// bit-serial restoring divider keeping the low quotient byte
module hcd_div
    import hcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output div_out_t         div_out
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [BYTE_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic              ge;
    logic [DVS_W:0]    rem_next;

    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign rem_next = ge ? (trial - {1'b0, dvs_reg}) : trial;

    assign div_out.done = done_reg;
    assign div_out.quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[BYTE_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/hcd_back.sv =====
// back end: adjugate, determinant, dot products and rounded division per byte
module hcd_back
    import hcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  block_t            q_data,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_plain_byte,
    output logic              m_final_result,
    output logic              m_singular_key
);

    typedef enum logic [2:0] {
        S_IDLE, S_ADJ, S_DET, S_MUL, S_SUM, S_DIV, S_OUT
    } state_t;

    state_t                   state_reg;
    block_t                   blk_reg;
    logic signed [ADJ_W-1:0]  adj_reg [3][3];
    logic signed [DET_W-1:0]  det_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    logic [ORD_W-1:0]         col_reg;
    logic                     neg_reg;
    logic                     m_valid_reg;
    logic [BYTE_W-1:0]        byte_reg;
    logic                     final_reg;
    logic                     sing_reg;

    logic [KEY_W-1:0]         k [3][3];
    logic signed [ADJ_W-1:0]  adj_c [3][3];
    logic signed [DET_W-1:0]  det_c;
    logic signed [NUM_W-1:0]  num_c;
    logic [NUM_W-1:0]         num_abs;
    logic [DET_W-1:0]         det_abs;
    logic                     div_start;
    logic [DVD_W-1:0]         dividend;
    logic [DVS_W-1:0]         divisor;
    div_out_t                 div_out;
    logic                     last_col;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                k[r][c] = cfg.key_rows[r][KEY_W*c +: KEY_W];
            end
        end
    end

    always_comb begin
        int r1;
        int r2;
        int c1;
        int c2;
        logic [2*KEY_W-1:0] p1;
        logic [2*KEY_W-1:0] p2;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                adj_c[r][c] = '0;
            end
        end
        case (blk_reg.order)
            2'd1: begin
                adj_c[0][0] = ADJ_W'(1);
            end
            2'd2: begin
                adj_c[0][0] = $signed({{(ADJ_W-KEY_W){1'b0}}, k[1][1]});
                adj_c[0][1] = -$signed({{(ADJ_W-KEY_W){1'b0}}, k[0][1]});
                adj_c[1][0] = -$signed({{(ADJ_W-KEY_W){1'b0}}, k[1][0]});
                adj_c[1][1] = $signed({{(ADJ_W-KEY_W){1'b0}}, k[0][0]});
            end
            default: begin
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r1 = (r == 2) ? 0 : r + 1;
                        r2 = (r == 0) ? 2 : r - 1;
                        c1 = (c == 2) ? 0 : c + 1;
                        c2 = (c == 0) ? 2 : c - 1;
                        p1 = k[r1][c1] * k[r2][c2];
                        p2 = k[r1][c2] * k[r2][c1];
                        adj_c[c][r] = $signed({2'b00, p1}) - $signed({2'b00, p2});
                    end
                end
            end
        endcase
    end

    always_comb begin
        det_c = '0;
        for (int j = 0; j < 3; j++) begin
            det_c = det_c + $signed({{(DET_W-KEY_W){1'b0}}, k[0][j]})
                          * $signed({{(DET_W-ADJ_W){adj_reg[j][0][ADJ_W-1]}}, adj_reg[j][0]});
        end
    end

    always_comb begin
        num_c = '0;
        for (int j = 0; j < 3; j++) begin
            num_c = num_c + NUM_W'(prod_reg[j]);
        end
        num_abs  = num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
        det_abs  = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        dividend = {num_abs[DVD_W-2:0], 1'b0} + DVD_W'(det_abs);
        divisor  = {det_abs[DVS_W-2:0], 1'b0};
    end

    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign div_start = (state_reg == S_SUM) && (det_reg != '0);
    assign last_col  = (col_reg == blk_reg.order - ORD_W'(1));

    hcd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .div_out  (div_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            col_reg     <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        blk_reg   <= q_data;
                        state_reg <= S_ADJ;
                    end
                end
                S_ADJ: begin
                    adj_reg   <= adj_c;
                    col_reg   <= '0;
                    state_reg <= S_DET;
                end
                S_DET: begin
                    det_reg   <= det_c;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    for (int j = 0; j < 3; j++) begin
                        prod_reg[j] <= $signed(blk_reg.vec[j]) * adj_reg[j][col_reg];
                    end
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    final_reg <= blk_reg.fin && last_col;
                    neg_reg   <= num_c[NUM_W-1] ^ det_reg[DET_W-1];
                    if (det_reg == '0) begin
                        byte_reg    <= '0;
                        sing_reg    <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        sing_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_out.done) begin
                        byte_reg    <= neg_reg ? BYTE_W'(-div_out.quo) : div_out.quo;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (last_col) begin
                            state_reg <= S_IDLE;
                        end else begin
                            col_reg   <= col_reg + ORD_W'(1);
                            state_reg <= S_MUL;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_plain_byte   = byte_reg;
    assign m_final_result = final_reg;
    assign m_singular_key = sing_reg;

endmodule

// ===== src/hill_cipher_decrypt_top.sv =====
// hill cipher decrypt top level
// Ciphertext values are gathered into row vectors of the configured order (1 to 3); a
// full vector or a value marked final closes the block, which is queued (two blocks
// deep) while the back end works. Each plaintext byte passes through the multiply, sum,
// 40-step serial divide and output states, which a block of order n repeats once per
// byte after its adjugate and determinant are formed, and each result transfer may wait
// on m_ready; with a singular key the divider is skipped. Input transfers continue while
// the queue has room.
// Registers: 0x0 matrix order, 0x4/0x8/0xC key rows, element 0 in the low byte.
module hill_cipher_decrypt_top
    import hcd_pkg::*;
#(
    parameter int MAX_ORDER = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_cipher_value,
    input  logic              s_final_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_plain_byte,
    output logic              m_final_result,
    output logic              m_singular_key
);

    localparam logic [1:0] REG_ORDER = 2'd0;
    localparam logic [1:0] REG_KEY0  = 2'd1;
    localparam logic [1:0] REG_KEY1  = 2'd2;
    localparam logic [1:0] REG_KEY2  = 2'd3;

    cfg_t   cfg_reg;
    logic   push;
    block_t push_data;
    logic   queue_full;
    logic   pop;
    logic   q_valid;
    block_t q_data;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.order    <= ORD_W'(3);
            cfg_reg.key_rows <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_ORDER: cfg_reg.order       <= pwdata[ORD_W-1:0];
                REG_KEY0:  cfg_reg.key_rows[0] <= pwdata[ROW_W-1:0];
                REG_KEY1:  cfg_reg.key_rows[1] <= pwdata[ROW_W-1:0];
                REG_KEY2:  cfg_reg.key_rows[2] <= pwdata[ROW_W-1:0];
                default:   cfg_reg.order       <= cfg_reg.order;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ORDER: prdata = 32'(cfg_reg.order);
            REG_KEY0:  prdata = 32'(cfg_reg.key_rows[0]);
            REG_KEY1:  prdata = 32'(cfg_reg.key_rows[1]);
            REG_KEY2:  prdata = 32'(cfg_reg.key_rows[2]);
            default:   prdata = '0;
        endcase
    end

    hcd_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cipher_value (s_cipher_value),
        .s_final_value  (s_final_value),
        .cfg_order      (cfg_reg.order),
        .queue_full     (queue_full),
        .push           (push),
        .push_data      (push_data)
    );

    hcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    hcd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_plain_byte   (m_plain_byte),
        .m_final_result (m_final_result),
        .m_singular_key (m_singular_key)
    );

endmodule
